// File: design/ffba_pkg.sv
package ffba_pkg;

   localparam int unsigned HEAP_BYTES   = 65536;
   localparam int unsigned MAX_BLOCKS   = 64;
   localparam int unsigned HEADER_BYTES = 32;
   localparam int unsigned ALIGN_BYTES  = 8;

   localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
   localparam int unsigned CNT_W  = IDX_W + 1;
   localparam int unsigned SIZE_W = 17;
   localparam int unsigned AL_W   = SIZE_W + 1;
   localparam int unsigned ENT_W  = SIZE_W + 1;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [SIZE_W-1:0] size_type;
   typedef logic [AL_W-1:0]   al_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NOSPACE = 3'd1,
      ST_NULL    = 3'd2,
      ST_UNKNOWN = 3'd3,
      ST_ZERO    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      KIND_ALLOC  = 2'd0,
      KIND_FREE   = 2'd1,
      KIND_RESIZE = 2'd2,
      KIND_CALLOC = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_RESIZE = 2'd2,
      OP_REFREE = 2'd3
   } op_type;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_MUL   = 7'b0000010,
      S_SCAN  = 7'b0000100,
      S_ACT   = 7'b0001000,
      S_SHIFT = 7'b0010000,
      S_FIN   = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   localparam int unsigned CSR_LIMIT = 0;

   // Oversized requests saturate to a value no block or limit can satisfy.
   localparam al_type AL_BIG = al_type'(2 * HEAP_BYTES);

   function automatic al_type round_al(input logic [63:0] v);
      al_type r;
      r = AL_BIG;
      if (v <= 64'(HEAP_BYTES))
         r = (al_type'(v) + al_type'(ALIGN_BYTES - 1)) & ~al_type'(ALIGN_BYTES - 1);
      return r;
   endfunction

endpackage

// File: design/ffba_ram.sv
module ffba_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: design/first_fit_block_allocator_top.sv
// Timing: request to response valid grows with the number of table entries, and further when
// a split inserts or a free merges and entries move; null free and zero array requests skip the
// scan, array requests add a multiply step, and a growing resize adds a second scan and merge.
// Throughput: one request at a time; the next request can be taken in the same cycle in which
// response valid rises, later while an earlier response is stalled.
// Reset (synchronous, active high) empties the table, clears heap top, sets heap_limit to 65536.
module first_fit_block_allocator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_address,
   input  logic [31:0] req_request_bytes,
   input  logic [31:0] req_element_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_result_address,
   output logic [16:0] rsp_copy_bytes,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ffba_pkg::*;

   localparam logic [AL_W-1:0] HDR = AL_W'(HEADER_BYTES);

   state_type  state_ff, state_in;
   op_type     op_ff, op_in;
   status_type status_ff, status_in;
   logic [15:0] res_ff, res_in, addr_ff, addr_in;
   size_type   copy_ff, copy_in;
   logic       grow_ff, grow_in;
   al_type     al_ff, al_in;
   logic [63:0] prod_ff, prod_in;
   size_type   limit_ff, top_ff, top_in;
   cnt_type    count_ff, count_in;

   cnt_type    rd_ff, rd_in, left_ff, left_in;
   logic       pv_ff, pv_in, up_ff, up_in;
   idx_type    pidx_ff, pidx_in, dist_ff, dist_in;

   logic [AL_W-1:0] off_ff, off_in;
   logic       fit_ff, fit_in;
   idx_type    fit_idx_ff, fit_idx_in;
   size_type   fit_size_ff, fit_size_in;
   logic [15:0] fit_pay_ff, fit_pay_in;
   logic       mf_ff, mf_in, mfree_ff, mfree_in;
   idx_type    midx_ff, midx_in;
   size_type   msize_ff, msize_in;
   logic       run_ff, run_in, mg_ff, mg_in;
   idx_type    run_start_ff, run_start_in, mg_start_ff, mg_start_in, mg_end_ff, mg_end_in;
   logic [AL_W-1:0] run_acc_ff, run_acc_in, mg_acc_ff, mg_acc_in;

   logic       fin_we_ff, fin_we_in;
   idx_type    fin_idx_ff, fin_idx_in;
   logic [ENT_W-1:0] fin_data_ff, fin_data_in;
   cnt_type    cnt_new_ff, cnt_new_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_res_ff, rsp_res_in;
   size_type   rsp_copy_ff, rsp_copy_in;

   logic       wr_en;
   idx_type    wr_addr, rd_addr;
   logic [ENT_W-1:0] wr_data, rd_data;

   logic            ent_fr;
   size_type        ent_sz;
   logic [AL_W-1:0] blk, pay, lim, apay;
   logic            issue, csr_wr;

   ffba_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BLOCKS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign ent_fr = rd_data[ENT_W-1];
   assign ent_sz = rd_data[SIZE_W-1:0];
   assign blk    = HDR + AL_W'(ent_sz);
   assign pay    = off_ff + HDR;
   assign lim    = (limit_ff > size_type'(HEAP_BYTES)) ? AL_W'(HEAP_BYTES) : AL_W'(limit_ff);
   assign apay   = AL_W'(top_ff) + HDR;
   assign issue  = (state_ff == S_SCAN) ? (rd_ff < count_ff) : (left_ff != '0);
   assign rd_addr = rd_ff[IDX_W-1:0];

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? 32'(limit_ff) : 32'd0;

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_address = rsp_res_ff;
   assign rsp_copy_bytes     = rsp_copy_ff;

   always_comb begin
      state_in = state_ff;   op_in = op_ff;       status_in = status_ff;
      res_in = res_ff;       addr_in = addr_ff;   copy_in = copy_ff;
      grow_in = grow_ff;
      al_in = al_ff;         prod_in = prod_ff;   top_in = top_ff;
      count_in = count_ff;   rd_in = rd_ff;       left_in = left_ff;
      pv_in = 1'b0;          up_in = up_ff;       pidx_in = pidx_ff;
      dist_in = dist_ff;     off_in = off_ff;     fit_in = fit_ff;
      fit_idx_in = fit_idx_ff; fit_size_in = fit_size_ff; fit_pay_in = fit_pay_ff;
      mf_in = mf_ff;         mfree_in = mfree_ff; midx_in = midx_ff;
      msize_in = msize_ff;   run_in = run_ff;     mg_in = mg_ff;
      run_start_in = run_start_ff; mg_start_in = mg_start_ff; mg_end_in = mg_end_ff;
      run_acc_in = run_acc_ff; mg_acc_in = mg_acc_ff;
      fin_we_in = fin_we_ff; fin_idx_in = fin_idx_ff; fin_data_in = fin_data_ff;
      cnt_new_in = cnt_new_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff; rsp_res_in = rsp_res_ff; rsp_copy_in = rsp_copy_ff;
      wr_en = 1'b0;          wr_addr = '0;        wr_data = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               status_in = ST_OK;  res_in = '0;  copy_in = '0;  grow_in = 1'b0;
               addr_in = req_address;
               al_in = round_al(64'(req_request_bytes));
               prod_in = 64'(req_request_bytes) * 64'(req_element_count);
               rd_in = '0;  off_in = '0;  fit_in = 1'b0;  mf_in = 1'b0;
               run_in = 1'b0;  mg_in = 1'b0;
               state_in = S_SCAN;
               case (kind_type'(req_kind))
                  KIND_ALLOC: op_in = OP_ALLOC;
                  KIND_FREE: begin
                     op_in = OP_FREE;
                     if (req_address == '0) begin
                        status_in = ST_NULL;
                        state_in = S_RESP;
                     end
                  end
                  KIND_CALLOC: begin
                     op_in = OP_ALLOC;
                     state_in = S_MUL;
                     if (req_request_bytes == '0 || req_element_count == '0) begin
                        status_in = ST_ZERO;
                        state_in = S_RESP;
                     end
                  end
                  default: begin
                     if (req_address == '0) op_in = OP_ALLOC;
                     else if (req_request_bytes == '0) op_in = OP_FREE;
                     else op_in = OP_RESIZE;
                  end
               endcase
            end
         end
         S_MUL: begin
            al_in = round_al(prod_ff);
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (issue) rd_in = rd_ff + 1'b1;
            pv_in = issue;
            pidx_in = rd_ff[IDX_W-1:0];
            if (pv_ff) begin
               off_in = off_ff + blk;
               if (!fit_ff && ent_fr && AL_W'(ent_sz) >= al_ff) begin
                  fit_in = 1'b1;  fit_idx_in = pidx_ff;
                  fit_size_in = ent_sz;  fit_pay_in = pay[15:0];
               end
               if (!mf_ff && pay == AL_W'(addr_ff)) begin
                  mf_in = 1'b1;  midx_in = pidx_ff;  mfree_in = ent_fr;  msize_in = ent_sz;
                  mg_in = 1'b1;  mg_end_in = pidx_ff;
                  mg_start_in = run_ff ? run_start_ff : pidx_ff;
                  mg_acc_in = (run_ff ? run_acc_ff : '0) + blk;
               end else if (mg_ff) begin
                  if (ent_fr) begin
                     mg_acc_in = mg_acc_ff + blk;
                     mg_end_in = pidx_ff;
                  end else begin
                     mg_in = 1'b0;
                  end
               end
               // free run ending just below the current entry
               if (ent_fr) begin
                  run_acc_in = run_ff ? run_acc_ff + blk : blk;
                  if (!run_ff) run_start_in = pidx_ff;
               end
               run_in = ent_fr;
            end
            if (!issue && !pv_ff) state_in = S_ACT;
         end
         S_ACT: begin
            fin_we_in = 1'b0;  left_in = '0;  cnt_new_in = count_ff;
            state_in = S_SHIFT;
            case (op_ff)
               OP_ALLOC: begin
                  if (fit_ff) begin
                     res_in = fit_pay_ff;
                     wr_en = 1'b1;  wr_addr = fit_idx_ff;
                     wr_data = {1'b0, fit_size_ff};
                     if (AL_W'(fit_size_ff) >= al_ff + HDR + AL_W'(ALIGN_BYTES)
                         && count_ff < cnt_type'(MAX_BLOCKS)) begin
                        wr_data = {1'b0, al_ff[SIZE_W-1:0]};
                        up_in = 1'b1;
                        rd_in = count_ff - 1'b1;
                        left_in = count_ff - cnt_type'(fit_idx_ff) - 1'b1;
                        fin_we_in = 1'b1;
                        fin_idx_in = fit_idx_ff + 1'b1;
                        fin_data_in = {1'b1, size_type'(AL_W'(fit_size_ff) - al_ff - HDR)};
                        cnt_new_in = count_ff + 1'b1;
                     end
                  end else if (count_ff >= cnt_type'(MAX_BLOCKS) || al_ff > lim
                               || (19'(apay) + 19'(al_ff)) > 19'(lim)
                               || apay > AL_W'(16'hFFFF)) begin
                     status_in = ST_NOSPACE;
                     copy_in = '0;
                     state_in = S_RESP;
                  end else begin
                     res_in = apay[15:0];
                     top_in = size_type'(apay + al_ff);
                     fin_we_in = 1'b1;
                     fin_idx_in = count_ff[IDX_W-1:0];
                     fin_data_in = {1'b0, al_ff[SIZE_W-1:0]};
                     cnt_new_in = count_ff + 1'b1;
                  end
               end
               OP_RESIZE: begin
                  if (!mf_ff || mfree_ff) begin
                     status_in = ST_UNKNOWN;
                     state_in = S_RESP;
                  end else if (AL_W'(msize_ff) >= al_ff) begin
                     res_in = addr_ff;
                     if (AL_W'(msize_ff) >= al_ff + HDR + AL_W'(ALIGN_BYTES)
                         && count_ff < cnt_type'(MAX_BLOCKS)) begin
                        wr_en = 1'b1;  wr_addr = midx_ff;
                        wr_data = {1'b0, al_ff[SIZE_W-1:0]};
                        up_in = 1'b1;
                        rd_in = count_ff - 1'b1;
                        left_in = count_ff - cnt_type'(midx_ff) - 1'b1;
                        fin_we_in = 1'b1;
                        fin_idx_in = midx_ff + 1'b1;
                        fin_data_in = {1'b1, size_type'(AL_W'(msize_ff) - al_ff - HDR)};
                        cnt_new_in = count_ff + 1'b1;
                     end
                  end else begin
                     // growth: the same scan already holds the first fit
                     copy_in = msize_ff;
                     grow_in = 1'b1;
                     op_in = OP_ALLOC;
                     state_in = S_ACT;
                  end
               end
               default: begin
                  if (!mf_ff || mfree_ff) begin
                     if (op_ff == OP_FREE) status_in = ST_UNKNOWN;
                     state_in = S_RESP;
                  end else begin
                     up_in = 1'b0;
                     dist_in = mg_end_ff - mg_start_ff;
                     rd_in = cnt_type'(mg_end_ff) + 1'b1;
                     left_in = count_ff - cnt_type'(mg_end_ff) - 1'b1;
                     fin_we_in = 1'b1;
                     fin_idx_in = mg_start_ff;
                     fin_data_in = {1'b1, size_type'(mg_acc_ff - HDR)};
                     cnt_new_in = count_ff - cnt_type'(mg_end_ff - mg_start_ff);
                  end
               end
            endcase
         end
         S_SHIFT: begin
            if (issue) begin
               rd_in = up_ff ? rd_ff - 1'b1 : rd_ff + 1'b1;
               left_in = left_ff - 1'b1;
            end
            pv_in = issue;
            pidx_in = rd_ff[IDX_W-1:0];
            if (pv_ff) begin
               wr_en = 1'b1;
               wr_addr = up_ff ? pidx_ff + 1'b1 : pidx_ff - dist_ff;
               wr_data = rd_data;
            end
            if (!issue && !pv_ff) state_in = S_FIN;
         end
         S_FIN: begin
            wr_en = fin_we_ff;  wr_addr = fin_idx_ff;  wr_data = fin_data_ff;
            count_in = cnt_new_ff;
            state_in = S_RESP;
            if (op_ff == OP_ALLOC && grow_ff) begin
               // growing resize: release the old block with a fresh scan
               op_in = OP_REFREE;
               rd_in = '0;  off_in = '0;  fit_in = 1'b1;  mf_in = 1'b0;
               run_in = 1'b0;  mg_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_res_in = (status_ff == ST_OK) ? res_ff : '0;
               rsp_copy_in = (status_ff == ST_OK) ? copy_ff : '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         top_ff <= '0;
         limit_ff <= size_type'(HEAP_BYTES);
         rsp_valid_ff <= 1'b0;
         pv_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         top_ff <= top_in;
         if (csr_wr && csr_paddr[2] == 1'(CSR_LIMIT)) limit_ff <= csr_pwdata[SIZE_W-1:0];
         rsp_valid_ff <= rsp_valid_in;
         pv_ff <= pv_in;
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;            status_ff <= status_in;   res_ff <= res_in;
      addr_ff <= addr_in;        copy_ff <= copy_in;       al_ff <= al_in;
      grow_ff <= grow_in;
      prod_ff <= prod_in;        rd_ff <= rd_in;           up_ff <= up_in;
      pidx_ff <= pidx_in;        dist_ff <= dist_in;       off_ff <= off_in;
      fit_ff <= fit_in;          fit_idx_ff <= fit_idx_in; fit_size_ff <= fit_size_in;
      fit_pay_ff <= fit_pay_in;  mf_ff <= mf_in;           mfree_ff <= mfree_in;
      midx_ff <= midx_in;        msize_ff <= msize_in;     run_ff <= run_in;
      mg_ff <= mg_in;            run_start_ff <= run_start_in;
      mg_start_ff <= mg_start_in; mg_end_ff <= mg_end_in;
      run_acc_ff <= run_acc_in;  mg_acc_ff <= mg_acc_in;
      fin_we_ff <= fin_we_in;    fin_idx_ff <= fin_idx_in; fin_data_ff <= fin_data_in;
      cnt_new_ff <= cnt_new_in;
      rsp_status_ff <= rsp_status_in; rsp_res_ff <= rsp_res_in; rsp_copy_ff <= rsp_copy_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(MAX_BLOCKS))
      else $error("block count past table size");

   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= size_type'(HEAP_BYTES))
      else $error("heap top past heap size");

   a_count_only_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_FIN) |=> $stable(count_ff))
      else $error("block count changed outside commit");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("response raised outside response state");

endmodule

// File: dv/first_fit_block_allocator_top_tb.sv
`timescale 1ns / 100ps

module first_fit_block_allocator_top_tb;
   import ffba_pkg::*;

   localparam int unsigned DRAIN_CYCLES = 400;
   localparam int unsigned STALL_LIMIT  = 6000;
   localparam int unsigned PHASE_ITEMS  = 240;

   typedef struct {
      kind_type    kind;
      logic [15:0] addr;
      logic [31:0] nbytes;
      logic [31:0] count;
      bit          typed;
      status_type  st;
      logic [15:0] res;
      logic [16:0] copy;
   } stim_row_type;

   typedef struct {
      status_type  st;
      logic [15:0] res;
      logic [16:0] copy;
   } grant_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_kind = 0;
   logic [15:0] req_address = 0;
   logic [31:0] req_request_bytes = 0;
   logic [31:0] req_element_count = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_result_address;
   logic [16:0] rsp_copy_bytes;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [2:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   first_fit_block_allocator_top uut (.*);

   always #2 clock = ~clock;

   // allocator mirror
   longint unsigned blk_size [MAX_BLOCKS];
   bit              blk_free [MAX_BLOCKS];
   int              blk_count;
   longint unsigned top_of_heap;
   longint unsigned limit_bytes;

   grant_type pending_grants[$];
   int     mismatches;
   int     quiet_cycles;
   bit     no_idle;
   int     stall_left;

   function automatic longint unsigned align8(longint unsigned n);
      return ((n + 7) / 8) * 8;
   endfunction

   function automatic longint unsigned payload_at(int idx);
      longint unsigned off;
      off = 0;
      for (int i = 0; i < idx && i < blk_count; i++) off += HEADER_BYTES + blk_size[i];
      return off + HEADER_BYTES;
   endfunction

   function automatic int used_index(longint unsigned a);
      longint unsigned off;
      off = 0;
      for (int i = 0; i < blk_count; i++) begin
         if (off + HEADER_BYTES == a) return blk_free[i] ? -1 : i;
         off += HEADER_BYTES + blk_size[i];
      end
      return -1;
   endfunction

   function automatic void drop_entry(int idx);
      for (int i = idx; i < blk_count - 1; i++) begin
         blk_size[i] = blk_size[i+1];
         blk_free[i] = blk_free[i+1];
      end
      blk_count--;
   endfunction

   function automatic void split_block(int idx, longint unsigned keep);
      if (blk_size[idx] >= keep + HEADER_BYTES + ALIGN_BYTES && blk_count < MAX_BLOCKS) begin
         for (int i = blk_count; i > idx + 1; i--) begin
            blk_size[i] = blk_size[i-1];
            blk_free[i] = blk_free[i-1];
         end
         blk_size[idx+1] = blk_size[idx] - keep - HEADER_BYTES;
         blk_free[idx+1] = 1;
         blk_size[idx] = keep;
         blk_count++;
      end
   endfunction

   function automatic status_type heap_alloc(longint unsigned al, output longint unsigned a);
      longint unsigned lim, pay;
      a = 0;
      for (int i = 0; i < blk_count; i++) begin
         if (blk_free[i] && blk_size[i] >= al) begin
            blk_free[i] = 0;
            split_block(i, al);
            a = payload_at(i);
            return ST_OK;
         end
      end
      lim = (limit_bytes < HEAP_BYTES) ? limit_bytes : HEAP_BYTES;
      pay = top_of_heap + HEADER_BYTES;
      if (blk_count >= MAX_BLOCKS || al > lim || pay + al > lim || pay > 64'hFFFF)
         return ST_NOSPACE;
      blk_size[blk_count] = al;
      blk_free[blk_count] = 0;
      blk_count++;
      top_of_heap = pay + al;
      a = pay;
      return ST_OK;
   endfunction

   function automatic status_type heap_free(longint unsigned a);
      int f;
      if (a == 0) return ST_NULL;
      f = used_index(a);
      if (f < 0) return ST_UNKNOWN;
      blk_free[f] = 1;
      while (f + 1 < blk_count && blk_free[f+1]) begin
         blk_size[f] += HEADER_BYTES + blk_size[f+1];
         drop_entry(f + 1);
      end
      while (f > 0 && blk_free[f-1]) begin
         blk_size[f-1] += HEADER_BYTES + blk_size[f];
         drop_entry(f);
         f--;
      end
      return ST_OK;
   endfunction

   function automatic grant_type heap_request(kind_type k, logic [15:0] a, logic [31:0] nb,
                                              logic [31:0] cnt);
      grant_type g;
      longint unsigned res, copy, al, old;
      int f;
      res = 0;
      copy = 0;
      g.st = ST_OK;
      if (k == KIND_ALLOC) begin
         g.st = heap_alloc(align8(nb), res);
      end else if (k == KIND_FREE) begin
         g.st = heap_free(a);
      end else if (k == KIND_CALLOC) begin
         if (nb == 0 || cnt == 0) g.st = ST_ZERO;
         else g.st = heap_alloc(align8(64'(nb) * 64'(cnt)), res);
      end else if (a == 0) begin
         g.st = heap_alloc(align8(nb), res);
      end else if (nb == 0) begin
         g.st = heap_free(a);
      end else begin
         al = align8(nb);
         f = used_index(a);
         if (f < 0) begin
            g.st = ST_UNKNOWN;
         end else if (blk_size[f] >= al) begin
            split_block(f, al);
            res = a;
         end else begin
            old = blk_size[f];
            g.st = heap_alloc(al, res);
            if (g.st == ST_OK) begin
               copy = old;
               void'(heap_free(a));
            end
         end
      end
      if (g.st != ST_OK) res = 0;
      g.res = res[15:0];
      g.copy = copy[16:0];
      return g;
   endfunction

   // payload offset of a random in-use block, 0 if none
   function automatic logic [15:0] live_address();
      int picks[$];
      for (int i = 0; i < blk_count; i++) if (!blk_free[i]) picks.push_back(i);
      if (picks.size() == 0) return '0;
      return 16'(payload_at(picks[$urandom_range(0, picks.size() - 1)]));
   endfunction

   task automatic send_request(stim_row_type r);
      grant_type g;
      req_kind <= r.kind;
      req_address <= r.addr;
      req_request_bytes <= r.nbytes;
      req_element_count <= r.count;
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      g = heap_request(r.kind, r.addr, r.nbytes, r.count);
      if (r.typed) begin
         g.st = r.st;
         g.res = r.res;
         g.copy = r.copy;
      end
      pending_grants.push_back(g);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic drain_and_idle();
      req_valid <= 0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(logic [31:0] v);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= 3'(CSR_LIMIT * 4);
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      limit_bytes = v & 32'h1FFFF;
   endtask

   function automatic stim_row_type random_row();
      stim_row_type r;
      int sel;
      r.typed = 0;
      r.kind = kind_type'($urandom_range(0, 3));
      r.count = $urandom_range(1, 8);
      sel = $urandom_range(0, 99);
      if (sel < 75) r.nbytes = $urandom_range(0, 600);
      else if (sel < 92) r.nbytes = $urandom_range(0, 6000);
      else if (sel < 96) r.nbytes = $urandom_range(60000, 70000);
      else r.nbytes = $urandom();
      if ($urandom_range(0, 19) == 0) r.count = $urandom();
      if (r.kind == KIND_CALLOC && $urandom_range(0, 9) == 0) r.count = 0;
      // mostly valid addresses, the rest noise or null
      sel = $urandom_range(0, 99);
      if (sel < 80) r.addr = live_address();
      else if (sel < 90) r.addr = 0;
      else r.addr = 16'($urandom());
      if (r.kind == KIND_FREE && r.addr == 0 && sel < 80) r.kind = KIND_ALLOC;
      return r;
   endfunction

   // response side: random stall bursts
   always @(posedge clock) begin
      if (reset || no_idle) begin
         rsp_stall <= 0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 15);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   always @(posedge clock) begin
      grant_type g;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_grants.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response: status %0d", rsp_status);
         end else begin
            g = pending_grants.pop_front();
            if (rsp_status !== g.st || rsp_result_address !== g.res
                || rsp_copy_bytes !== g.copy) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st %0d addr %0d copy %0d, got st %0d addr %0d copy %0d",
                           g.st, g.res, g.copy, rsp_status, rsp_result_address,
                           rsp_copy_bytes);
            end
         end
      end
   end

   // watchdog: cycles without any accepted transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      stim_row_type directed[] = '{
         '{KIND_ALLOC,  16'd0,     32'd0,          32'd0,          1, ST_OK,      16'd32, 17'd0},
         '{KIND_ALLOC,  16'd0,     32'd1,          32'd0,          1, ST_OK,      16'd64, 17'd0},
         '{KIND_FREE,   16'd0,     32'd0,          32'd0,          1, ST_NULL,    16'd0,  17'd0},
         '{KIND_FREE,   16'hFFFF,  32'd0,          32'd0,          1, ST_UNKNOWN, 16'd0,  17'd0},
         '{KIND_CALLOC, 16'd0,     32'd5,          32'd0,          1, ST_ZERO,    16'd0,  17'd0},
         '{KIND_CALLOC, 16'd0,     32'd0,          32'hFFFFFFFF,   1, ST_ZERO,    16'd0,  17'd0},
         '{KIND_CALLOC, 16'd0,     32'hFFFFFFFF,   32'hFFFFFFFF,   1, ST_NOSPACE, 16'd0,  17'd0},
         '{KIND_ALLOC,  16'd0,     32'hFFFFFFFF,   32'd0,          1, ST_NOSPACE, 16'd0,  17'd0},
         '{KIND_RESIZE, 16'hAAAA,  32'd8,          32'd0,          1, ST_UNKNOWN, 16'd0,  17'd0},
         '{KIND_FREE,   16'd64,    32'd0,          32'd0,          1, ST_OK,      16'd0,  17'd0},
         '{KIND_FREE,   16'd64,    32'd0,          32'd0,          1, ST_UNKNOWN, 16'd0,  17'd0},
         '{KIND_RESIZE, 16'd0,     32'd16,         32'd0,          0, ST_OK,      16'd0,  17'd0},
         '{KIND_RESIZE, 16'd104,   32'd0,          32'd0,          0, ST_OK,      16'd0,  17'd0},
         '{KIND_CALLOC, 16'd0,     32'd3,          32'd5,          0, ST_OK,      16'd0,  17'd0},
         '{KIND_ALLOC,  16'd0,     32'd200,        32'd0,          0, ST_OK,      16'd0,  17'd0},
         '{KIND_RESIZE, 16'd32,    32'd40,         32'd0,          0, ST_OK,      16'd0,  17'd0},
         '{KIND_RESIZE, 16'd104,   32'd8,          32'd0,          0, ST_OK,      16'd0,  17'd0},
         '{KIND_RESIZE, 16'd104,   32'd200,        32'd0,          0, ST_OK,      16'd0,  17'd0},
         '{KIND_ALLOC,  16'd0,     32'd65536,      32'd0,          0, ST_OK,      16'd0,  17'd0},
         '{KIND_ALLOC,  16'd0,     32'd60000,      32'd0,          0, ST_OK,      16'd0,  17'd0},
         '{KIND_FREE,   16'h5555,  32'h55555555,   32'hAAAAAAAA,   0, ST_OK,      16'd0,  17'd0}
      };
      logic [31:0] limits[5] = '{32'd65536, 32'd0, 32'd4096, 32'h1FFFF, 32'd65536};
      blk_count = 0;
      top_of_heap = 0;
      limit_bytes = 65536;
      mismatches = 0;
      no_idle = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[i]) send_request(directed[i]);
      for (int p = 0; p < 5; p++) begin
         drain_and_idle();
         write_limit(limits[p]);
         if (p == 4) no_idle = 1;
         for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_row());
      end
      drain_and_idle();
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
